>>> src/s2da_pkg.sv
// shared constants, types and controller codes for the signed integer to decimal text core
// no dependencies; used by s2da_ctrl, s2da_dp and the top level
package s2da_pkg;

    // input width and derived sizes
    localparam int VALUE_BITS    = 32;
    localparam int BITS_PER_STEP = 4;
    localparam int STEPS         = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PAD_BITS      = STEPS * BITS_PER_STEP;
    // decimal digits of any VALUE_BITS-bit unsigned magnitude (1233/4096 ~ log10 2)
    localparam int DIGITS        = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_BITS      = DIGITS * 4;
    localparam int IDX_W         = $clog2(DIGITS);
    localparam int CNT_W         = $clog2(STEPS);
    localparam int CHAR_W        = 8;

    // character codes
    localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd48;
    localparam logic [CHAR_W-1:0] MINUS_CODE = 8'd45;

    // controller state codes
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] ST_CONV  = 3'd1;
    localparam logic [ST_W-1:0] ST_SCAN  = 3'd2;
    localparam logic [ST_W-1:0] ST_SIGN  = 3'd3;
    localparam logic [ST_W-1:0] ST_DIGIT = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic scan;
        logic next_digit;
        logic sel_minus;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic neg;
        logic idx_zero;
    } t_stat;

endpackage

>>> src/s2da_dp.sv
// datapath: magnitude, shift-add-3 binary to bcd conversion, leading digit index, char select
// depends on s2da_pkg
module s2da_dp (
    input  logic                                i_clk,
    input  s2da_pkg::t_cmd                      i_cmd,
    input  logic [s2da_pkg::VALUE_BITS-1:0]     i_value,
    output s2da_pkg::t_stat                     o_stat,
    output logic [s2da_pkg::CHAR_W-1:0]         o_char_code
);

    logic [s2da_pkg::PAD_BITS-1:0]   r_shift;
    logic [s2da_pkg::BCD_BITS-1:0]   r_bcd;
    logic                            r_neg;
    logic [s2da_pkg::IDX_W-1:0]      r_idx;

    logic [s2da_pkg::VALUE_BITS-1:0] n_mag;
    logic [s2da_pkg::PAD_BITS-1:0]   n_shift;
    logic [s2da_pkg::BCD_BITS-1:0]   n_bcd;
    logic [s2da_pkg::IDX_W-1:0]      n_lead;
    logic [3:0]                      w_digit;

    // magnitude of the two's complement input
    assign n_mag = i_value[s2da_pkg::VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;

    // one conversion step: several bits, each an add-3 pass then a shift
    always_comb begin
        logic [s2da_pkg::PAD_BITS-1:0] sh;
        logic [s2da_pkg::BCD_BITS-1:0] bc;
        sh = r_shift;
        bc = r_bcd;
        for (int j = 0; j < s2da_pkg::BITS_PER_STEP; j++) begin
            for (int d = 0; d < s2da_pkg::DIGITS; d++) begin
                if (bc[d*4 +: 4] >= 4'd5) begin
                    bc[d*4 +: 4] = bc[d*4 +: 4] + 4'd3;
                end
            end
            bc = {bc[s2da_pkg::BCD_BITS-2:0], sh[s2da_pkg::PAD_BITS-1]};
            sh = {sh[s2da_pkg::PAD_BITS-2:0], 1'b0};
        end
        n_shift = sh;
        n_bcd   = bc;
    end

    // index of the most significant nonzero digit, zero when all digits are zero
    always_comb begin
        n_lead = '0;
        for (int d = 0; d < s2da_pkg::DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] != 4'd0) begin
                n_lead = s2da_pkg::IDX_W'(d);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_shift <= s2da_pkg::PAD_BITS'(n_mag);
            r_bcd   <= '0;
            r_neg   <= i_value[s2da_pkg::VALUE_BITS-1];
        end else if (i_cmd.step) begin
            r_shift <= n_shift;
            r_bcd   <= n_bcd;
        end
        if (i_cmd.scan) begin
            r_idx <= n_lead;
        end else if (i_cmd.next_digit) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    // character select
    assign w_digit     = r_bcd[r_idx*4 +: 4];
    assign o_char_code = i_cmd.sel_minus ? s2da_pkg::MINUS_CODE
                                         : s2da_pkg::DIGIT_BASE + {4'b0000, w_digit};

    assign o_stat.neg      = r_neg;
    assign o_stat.idx_zero = (r_idx == '0);

endmodule

>>> src/s2da_ctrl.sv
// controller: sequences load, conversion steps, digit scan and character output
// depends on s2da_pkg
module s2da_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_stall,
    input  s2da_pkg::t_stat i_stat,
    output s2da_pkg::t_cmd  o_cmd,
    output logic            o_stall,
    output logic            o_valid,
    output logic            o_last
);

    logic [s2da_pkg::ST_W-1:0]  r_state;
    logic [s2da_pkg::ST_W-1:0]  n_state;
    logic [s2da_pkg::CNT_W-1:0] r_cnt;
    logic [s2da_pkg::CNT_W-1:0] n_cnt;

    // next state and commands; in the output states o_valid is high, so an
    // output item is taken whenever i_stall is low
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        o_last  = 1'b0;
        case (r_state)
            s2da_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = s2da_pkg::ST_CONV;
                end
            end
            s2da_pkg::ST_CONV: begin
                o_cmd.step = 1'b1;
                if (r_cnt == s2da_pkg::CNT_W'(s2da_pkg::STEPS - 1)) begin
                    n_state = s2da_pkg::ST_SCAN;
                end else begin
                    n_cnt = r_cnt + s2da_pkg::CNT_W'(1);
                end
            end
            s2da_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state    = i_stat.neg ? s2da_pkg::ST_SIGN : s2da_pkg::ST_DIGIT;
            end
            s2da_pkg::ST_SIGN: begin
                o_valid         = 1'b1;
                o_cmd.sel_minus = 1'b1;
                if (!i_stall) begin
                    n_state = s2da_pkg::ST_DIGIT;
                end
            end
            s2da_pkg::ST_DIGIT: begin
                o_valid = 1'b1;
                o_last  = i_stat.idx_zero;
                if (!i_stall) begin
                    if (i_stat.idx_zero) begin
                        n_state = s2da_pkg::ST_IDLE;
                    end else begin
                        o_cmd.next_digit = 1'b1;
                    end
                end
            end
            default: begin
                n_state = s2da_pkg::ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= s2da_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> src/signed_int_to_decimal_ascii_core.sv
// top level: signed integer to decimal ascii text, one character per output item
// depends on s2da_pkg, s2da_ctrl, s2da_dp
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+------------------------
//  input   | i_valid | o_stall | i_value
//  output  | o_valid | i_stall | o_char_code, o_last
//
// an item at 32 bits gives n = 1..11 characters: the item is accepted, converted
// four bits per cycle through the add-3 unit, scanned for the leading digit, then
// sent as one character per cycle while i_stall is low
// o_stall is high after acceptance until the last character is taken
// a stalled output holds its character; synchronous active-low reset returns to idle
module signed_int_to_decimal_ascii_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [s2da_pkg::VALUE_BITS-1:0] i_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [s2da_pkg::CHAR_W-1:0]     o_char_code,
    output logic                            o_last
);

    s2da_pkg::t_cmd  w_cmd;
    s2da_pkg::t_stat w_stat;

    // sequencing
    s2da_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_last  (o_last)
    );

    // conversion and character select
    s2da_dp u_dp (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_value     (i_value),
        .o_stat      (w_stat),
        .o_char_code (o_char_code)
    );

endmodule

>>> src/s2da_checker.sv
// port-level checks for the signed integer to decimal text core, bound to the top level
// depends on s2da_pkg and signed_int_to_decimal_ascii_core
module s2da_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic [s2da_pkg::VALUE_BITS-1:0] i_value,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [s2da_pkg::CHAR_W-1:0]     o_char_code,
    input logic                            o_last
);

    // a stalled character holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_char_code) && $stable(o_last))
        else $error("stalled output item changed");

    // no new item is taken while characters are pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input ready while output pending");

    // conversion takes time after an accepted item
    a_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !o_valid)
        else $error("output valid right after input accept");

    // nothing more follows the last character
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last |=> !o_valid && !o_stall)
        else $error("output continued after last item");

    // minus sign never ends a number, characters are minus or digits
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == s2da_pkg::MINUS_CODE && !o_last) ||
                    (o_char_code >= s2da_pkg::DIGIT_BASE && o_char_code <= 8'd57))
        else $error("bad output character");

endmodule

bind signed_int_to_decimal_ascii_core s2da_checker u_s2da_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_value     (i_value),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_char_code (o_char_code),
    .o_last      (o_last)
);
